// ===== hw/rtl/moving_average_filter_macros.svh =====
// Assertion macros shared by the moving average filter checker.
`ifndef MOVING_AVERAGE_FILTER_MACROS_SVH
`define MOVING_AVERAGE_FILTER_MACROS_SVH

// Assertion sampled on the rising clock edge, switched off while reset is asserted.
`define MAVG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Assertion sampled on the rising clock edge that also holds during reset.
`define MAVG_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== hw/rtl/mavg_pkg.sv =====
// Package with the shared constants of the moving average filter.
package mavg_pkg;

  // Default longest window, in samples.
  localparam int unsigned MaxWindowDef = 1024;
  // Default sample width, in bits.
  localparam int unsigned SampleBitsDef = 16;
  // Width of the window length register.
  localparam int unsigned WinRegBits = 11;

endpackage

// ===== hw/rtl/mavg_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module mavg_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 1024,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [Width-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [Width-1:0] rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== hw/rtl/moving_average_filter.sv =====
// Top level of the boxcar moving average filter with a bit-serial divider.
//
// Usage: a request on the input channel (in_valid_i / in_ready_o) carries one
// signed sample. For every request the block returns exactly one average on the
// output channel (out_valid_o / out_ready_i): the sum of the last window_length
// samples divided by window_length, truncated toward zero. Before the delay
// line has filled, the missing older samples count as zero.
// The block handles one request at a time: it takes no new one until the
// current request has passed the history read, the sum update, the sign
// split, the restoring divider, which retires one quotient bit per cycle,
// and the hand-off to the output register.
// The output register decouples the two sides: while a result waits for
// out_ready_i the block already accepts and processes the next request, and it
// only holds in its final step if the previous result has still not been taken.
// Reset (rst_ni low) sets the window length to 1 and clears the running sum,
// the write pointer and the fill flag. The history RAM itself is never cleared:
// a fill flag makes unwritten entries read as zero. Writing the window length
// (cfg_we_i) does the same clearing and must happen only while the block is idle.
module moving_average_filter
  import mavg_pkg::*;
#(
  parameter int unsigned MAX_WINDOW  = MaxWindowDef,
  parameter int unsigned SAMPLE_BITS = SampleBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Input request channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_in_i,
  // Output request channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [SAMPLE_BITS-1:0] average_out_o,
  // Configuration write port
  input  logic                          cfg_we_i,
  input  logic [WinRegBits-1:0]         window_length_i
);

  // Address of one history slot.
  localparam int unsigned AddrW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  // Width that holds any window length up to and including MAX_WINDOW.
  localparam int unsigned LenW  = $clog2(MAX_WINDOW + 1);
  // Extra sum bits needed for MAX_WINDOW samples.
  localparam int unsigned LogW  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 0;
  // The running sum spans MAX_WINDOW full-scale samples exactly.
  localparam int unsigned SumW  = SAMPLE_BITS + LogW;
  // Divide step counter.
  localparam int unsigned CntW  = $clog2(SAMPLE_BITS);

  typedef enum logic [2:0] {
    StIdle,
    StUpdate,
    StPrep,
    StDivide,
    StFinish
  } state_e;

  state_e                   state_q;
  logic [LenW-1:0]          len_q;
  logic [AddrW-1:0]         pos_q;
  logic                     wrapped_q;
  logic signed [SumW-1:0]   sum_q;
  logic signed [SAMPLE_BITS-1:0] sample_q;
  logic                     neg_q;
  logic [LenW-1:0]          rem_q;
  logic [SAMPLE_BITS-1:0]   div_q;
  logic [CntW-1:0]          cnt_q;
  logic                     out_valid_q;
  logic [SAMPLE_BITS-1:0]   avg_q;

  logic                     in_fire;
  logic [SAMPLE_BITS-1:0]   ram_rd_data;
  logic signed [SAMPLE_BITS-1:0] oldest;
  logic signed [SumW-1:0]   sum_d;
  logic [LenW-1:0]          pos_inc;
  logic [SumW-1:0]          mag;
  logic [LenW+1:0]          trial;
  logic [LenW:0]            shifted_rem;
  logic                     q_bit;
  logic [LenW-1:0]          rem_d;
  logic [LenW-1:0]          cfg_len;
  logic                     can_load;

  // A register write takes the idle cycle, so no request is taken beside it.
  assign in_ready_o = (state_q == StIdle) && !cfg_we_i;
  assign in_fire    = in_valid_i && in_ready_o;

  // The history RAM: read the oldest slot on acceptance, overwrite it in the next cycle.
  mavg_ram #(
    .Width (SAMPLE_BITS),
    .Depth (MAX_WINDOW)
  ) u_history (
    .clk_i     (clk_i),
    .wr_en_i   (state_q == StUpdate),
    .wr_addr_i (pos_q),
    .wr_data_i (sample_q),
    .rd_en_i   (in_fire),
    .rd_addr_i (pos_q),
    .rd_data_o (ram_rd_data)
  );

  // Until the pointer has wrapped once, the slot at the pointer was never
  // written since the last clear and stands for a zero sample.
  assign oldest  = wrapped_q ? $signed(ram_rd_data) : '0;
  assign sum_d   = sum_q + SumW'(sample_q) - SumW'(oldest);
  assign pos_inc = LenW'(pos_q) + LenW'(1);

  // Magnitude of the running sum; the sign is applied after the division.
  assign mag = sum_q[SumW-1] ? SumW'(-sum_q) : SumW'(sum_q);

  // One restoring divide step: bring in the next dividend bit and try to
  // subtract the window length.
  assign shifted_rem = {rem_q, div_q[SAMPLE_BITS-1]};
  assign trial       = {1'b0, shifted_rem} - {2'b00, len_q};
  assign q_bit       = !trial[LenW+1];
  assign rem_d       = q_bit ? trial[LenW-1:0] : shifted_rem[LenW-1:0];

  // Window length as it takes effect: zero acts as one, large values saturate.
  always_comb begin
    if (window_length_i == '0) begin
      cfg_len = LenW'(1);
    end else if (32'(window_length_i) > MAX_WINDOW) begin
      cfg_len = LenW'(MAX_WINDOW);
    end else begin
      cfg_len = LenW'(window_length_i);
    end
  end

  assign can_load = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      len_q       <= LenW'(1);
      pos_q       <= '0;
      wrapped_q   <= 1'b0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
      avg_q       <= '0;
    end else begin
      // In the final step the output register is reloaded by the case below.
      if (out_valid_q && out_ready_i && (state_q != StFinish)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (cfg_we_i) begin
            len_q     <= cfg_len;
            pos_q     <= '0;
            wrapped_q <= 1'b0;
            sum_q     <= '0;
          end else if (in_fire) begin
            state_q <= StUpdate;
          end
        end
        StUpdate: begin
          sum_q <= sum_d;
          if (pos_inc >= len_q) begin
            pos_q     <= '0;
            wrapped_q <= 1'b1;
          end else begin
            pos_q <= AddrW'(pos_inc);
          end
          state_q <= StPrep;
        end
        StPrep: begin
          state_q <= StDivide;
        end
        StDivide: begin
          if (cnt_q == '0) begin
            state_q <= StFinish;
          end
        end
        StFinish: begin
          if (can_load) begin
            out_valid_q <= 1'b1;
            avg_q       <= neg_q ? SAMPLE_BITS'(-div_q) : div_q;
            state_q     <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  // Datapath registers of the divider and the captured sample.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      sample_q <= sample_in_i;
    end
    if (state_q == StPrep) begin
      // The quotient fits in SAMPLE_BITS bits, so the bits above the low
      // SAMPLE_BITS already form a partial remainder below the window length.
      neg_q <= sum_q[SumW-1];
      rem_q <= LenW'(mag >> SAMPLE_BITS);
      div_q <= mag[SAMPLE_BITS-1:0];
      cnt_q <= CntW'(SAMPLE_BITS - 1);
    end else if (state_q == StDivide) begin
      rem_q <= rem_d;
      div_q <= {div_q[SAMPLE_BITS-2:0], q_bit};
      cnt_q <= cnt_q - CntW'(1);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign average_out_o = $signed(avg_q);

endmodule

// ===== hw/rtl/mavg_checker.sv =====
// Port-level checker for the moving average filter, bound to its top level.
`include "moving_average_filter_macros.svh"

module mavg_checker
  import mavg_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = SampleBitsDef
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_ready_o,
  input logic                   out_valid_o,
  input logic                   out_ready_i,
  input logic [SAMPLE_BITS-1:0] average_out_o
);

  // A result that waits for the receiver stays put.
  `MAVG_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(average_out_o), "result changed while stalled")

  // Reset leaves no result pending.
  `MAVG_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> !out_valid_o, "result pending after reset")

  // The block works on one request at a time.
  `MAVG_ASSERT(a_one_at_a_time, in_valid_i && in_ready_o |=> !in_ready_o, "request taken while busy")

  // A new result never appears in the cycle right after a request was taken.
  `MAVG_ASSERT(a_min_latency, $rose(out_valid_o) |-> !$past(in_valid_i && in_ready_o), "result too early")

endmodule

bind moving_average_filter mavg_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_mavg_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .average_out_o   (average_out_o)
);

// ===== sim/moving_average_checker.sv =====
// Scoreboard for the moving average filter: predicts each average and compares it.
module moving_average_checker
  import mavg_pkg::*;
#(
  parameter int unsigned MAX_WINDOW  = MaxWindowDef,
  parameter int unsigned SAMPLE_BITS = SampleBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic signed [SAMPLE_BITS-1:0] average_i,
  input  logic                          cfg_we_i,
  input  logic [WinRegBits-1:0]         window_length_i,
  output int                            pending_o,
  output int                            checked_o,
  output int                            fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PtrBits = $clog2(MAX_WINDOW);
  localparam int unsigned SumBits = SAMPLE_BITS + PtrBits;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  sample_t                   delay_line [MAX_WINDOW];
  logic [PtrBits-1:0]        oldest_slot;
  logic signed [SumBits-1:0] window_sum;
  logic [WinRegBits-1:0]     window_reg;
  sample_t                   pending_averages [$];
  sample_t                   wanted;

  // Zero and oversized register values fall back to the nearest legal length.
  function automatic int unsigned span_length();
    if (window_reg == '0) return 1;
    if (window_reg > MAX_WINDOW) return MAX_WINDOW;
    return 32'(window_reg);
  endfunction

  function automatic void clear_window();
    foreach (delay_line[i]) delay_line[i] = '0;
    oldest_slot = '0;
    window_sum  = '0;
  endfunction

  // Replaces the oldest sample with the new one and returns the truncated mean.
  function automatic sample_t push_sample(sample_t s);
    int unsigned span;
    int unsigned slot;
    sample_t     dropped;
    longint      quotient;
    span = span_length();
    slot = 32'(oldest_slot);
    if (slot >= span) slot = 0;
    dropped          = delay_line[slot];
    delay_line[slot] = s;
    window_sum       = window_sum + SumBits'(s) - SumBits'(dropped);
    slot = slot + 1;
    if (slot >= span) slot = 0;
    oldest_slot = slot[PtrBits-1:0];
    // Signed division in SystemVerilog already truncates toward zero.
    quotient = longint'(window_sum) / longint'(span);
    return quotient[SAMPLE_BITS-1:0];
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_reg = WinRegBits'(1);
      clear_window();
      pending_averages.delete();
    end else begin
      if (cfg_we_i) begin
        window_reg = window_length_i;
        clear_window();
      end
      // Compare before pushing so a result never meets its own expectation.
      if (out_valid_i && out_ready_i) begin
        if (pending_averages.size() == 0) begin
          report_mismatch($sformatf("average %0d arrived with none expected", average_i));
        end else begin
          wanted = pending_averages.pop_front();
          if (average_i !== wanted) begin
            report_mismatch($sformatf("average %0d: got %0d, expected %0d",
                                      checked_o, average_i, wanted));
          end
          checked_o++;
        end
      end
      if (in_valid_i && in_ready_i) pending_averages.push_back(push_sample(sample_i));
    end
    pending_o = pending_averages.size();
  end

endmodule

// ===== sim/moving_average_filter_tb.sv =====
// Top of the moving average filter testbench: clock, reset, stimulus and verdict.
module moving_average_filter_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mavg_pkg::*;

  localparam int unsigned SampleBits = SampleBitsDef;
  localparam int unsigned MaxWindow  = MaxWindowDef;
  // How long one request occupies the block, from acceptance until it is ready again.
  localparam int unsigned ItemCycles  = SampleBits + 4;
  localparam int unsigned DrainCycles = 2 * ItemCycles;
  // Sum of the random phases below; the idle pattern changes at its thirds.
  localparam int unsigned RandomTotal = 1930;
  // This leaves a wide margin over the slowest legal run.
  localparam int unsigned CycleLimit  = 600_000;

  typedef logic signed [SampleBits-1:0] sample_t;
  typedef enum int unsigned {MixedValues, NearTop, NearBottom} sample_style_e;

  localparam sample_t SampleMax = {1'b0, {(SampleBits-1){1'b1}}};
  localparam sample_t SampleMin = {1'b1, {(SampleBits-1){1'b0}}};

  logic                  clk_i           = 1'b0;
  logic                  rst_ni          = 1'b0;
  logic                  in_valid_i      = 1'b0;
  sample_t               sample_in_i     = '0;
  logic                  out_ready_i     = 1'b0;
  logic                  cfg_we_i        = 1'b0;
  logic [WinRegBits-1:0] window_length_i = '0;
  logic                  in_ready_o;
  logic                  out_valid_o;
  sample_t               average_out_o;

  int          pending;
  int          checked;
  int          fail_count;
  int          send_idle_pct = 28;
  int          recv_idle_pct = 69;
  int unsigned random_done   = 0;
  int unsigned sent_samples  = 0;
  int unsigned window_writes = 0;
  int unsigned cycle_count   = 0;

  always #2 clk_i = ~clk_i;

  moving_average_filter #(
    .MAX_WINDOW (MaxWindow),
    .SAMPLE_BITS(SampleBits)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .sample_in_i    (sample_in_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .average_out_o  (average_out_o),
    .cfg_we_i       (cfg_we_i),
    .window_length_i(window_length_i)
  );

  // The checker sees both channels and the register port, and owns all
  // prediction; this module only drives the block and reads back counts.
  moving_average_checker #(
    .MAX_WINDOW (MaxWindow),
    .SAMPLE_BITS(SampleBits)
  ) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .sample_i       (sample_in_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .average_i      (average_out_o),
    .cfg_we_i       (cfg_we_i),
    .window_length_i(window_length_i),
    .pending_o      (pending),
    .checked_o      (checked),
    .fail_count_o   (fail_count)
  );

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Timed out after %0d cycles with %0d averages outstanding.",
               cycle_count, pending);
      $display("FAIL");
      $finish;
    end
  end

  // Output side back-pressure. Ready is drawn in short bursts that hold one
  // value, low with the current idle percentage, so that stalls of varying
  // length line up with every step of the block's divider.
  initial begin
    @(posedge rst_ni);
    forever begin
      out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
  end

  // Picks a sample. The style changes every 300 requests of a phase so that
  // long windows see stretches near both ends of the range, which drive the
  // running sum close to its limits, between stretches of mixed values.
  function automatic sample_t draw_sample(int unsigned k);
    sample_style_e style;
    style = sample_style_e'((k / 300) % 3);
    case (style)
      NearTop: begin
        if ($urandom_range(0, 3) != 0) return SampleMax - sample_t'($urandom_range(0, 15));
        return sample_t'($urandom_range(0, 65535));
      end
      NearBottom: begin
        if ($urandom_range(0, 3) != 0) return SampleMin + sample_t'($urandom_range(0, 15));
        return sample_t'($urandom_range(0, 65535));
      end
      default: begin
        case ($urandom_range(0, 7))
          0:       return SampleMax;
          1:       return SampleMin;
          2:       return sample_t'($urandom_range(0, 1)) - sample_t'(1);
          default: return sample_t'($urandom_range(0, 65535));
        endcase
      end
    endcase
  endfunction

  // Sends one request. It is always entered at the falling edge right after
  // the previous request was accepted, so valid either carries the new sample
  // or drops at that very edge, and is never lowered and raised in one step.
  // A gap, when drawn, lasts long enough to land anywhere in the block's work.
  task automatic send_sample(input sample_t s);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, ItemCycles + 4)) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    sample_in_i <= s;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    sent_samples++;
  endtask

  // Writes the window length once every outstanding average has been taken.
  // Each request yields exactly one average, so the block is idle by then.
  task automatic set_window(input logic [WinRegBits-1:0] len);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    cfg_we_i        <= 1'b1;
    window_length_i <= len;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    window_writes++;
  endtask

  // One random phase: a window setting followed by n requests. The idle
  // pattern follows the overall random count: sender light and receiver
  // heavy first, then the reverse, then no idling at all.
  task automatic run_phase(input logic [WinRegBits-1:0] len, input int unsigned n);
    set_window(len);
    for (int unsigned k = 0; k < n; k++) begin
      if (random_done == RandomTotal / 3) begin
        send_idle_pct = 69;
        recv_idle_pct = 28;
      end else if (random_done == 2 * RandomTotal / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      send_sample(draw_sample(k));
      random_done++;
    end
  endtask

  initial begin
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // The window is one sample after reset, so each average is the sample.
    send_sample(SampleMax);
    send_sample(SampleMin);
    send_sample('0);
    send_sample(-sample_t'(1));
    send_sample(sample_t'(1));

    // A short window filled with each extreme, then two small samples that are
    // averaged with the largest sample still in the window.
    set_window(WinRegBits'(3));
    repeat (4) send_sample(SampleMin);
    repeat (4) send_sample(SampleMax);
    send_sample(sample_t'(1));
    send_sample(-sample_t'(2));

    // Rewriting the same length still has to clear the history.
    set_window(WinRegBits'(3));
    send_sample(sample_t'(100));

    // A zero length behaves as a one-sample window.
    set_window('0);
    send_sample(sample_t'(5));
    send_sample(-sample_t'(7));

    // The largest register value saturates to the longest window.
    set_window('1);
    repeat (3) send_sample(SampleMin);
    send_sample(SampleMax);

    // Random phases. The full-length window runs past one wrap of the
    // delay line; short windows wrap constantly.
    run_phase(WinRegBits'(MaxWindow), 1080);
    run_phase(WinRegBits'(7), 200);
    run_phase(WinRegBits'(2), 150);
    run_phase(WinRegBits'(1), 100);
    run_phase(WinRegBits'($urandom_range(3, MaxWindow - 1)), 150);
    run_phase(WinRegBits'(1500), 150);
    run_phase(WinRegBits'(13), 100);

    // Drain: every average must arrive, and nothing may follow it.
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);

    $display("Covered %0d samples across %0d window writes; %0d averages compared.",
             sent_samples, window_writes, checked);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("Mismatches: %0d", fail_count);
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== moving_average_filter.f =====
+incdir+hw/rtl
hw/rtl/mavg_pkg.sv
hw/rtl/mavg_ram.sv
hw/rtl/moving_average_filter.sv
hw/rtl/mavg_checker.sv
sim/moving_average_checker.sv
sim/moving_average_filter_tb.sv
